### design/zrle_pkg.sv
// Shared types and constants for the zero run length encoder.
// Holds the controller states, result kinds and the command/status structs.
// No dependencies.
package zrle_pkg;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_LIT,
        S_ESC,
        S_FOOT
    } t_state;

    // What the datapath puts into the output register on an emit
    typedef enum logic [1:0] {
        K_RUN_BIT,
        K_LITERAL,
        K_ESC_TAIL,
        K_FOOTER
    } t_kind;

    // Controller to datapath
    typedef struct packed {
        logic  accept;     // input request taken this cycle
        logic  run_start;  // begin flushing the pending zero run
        logic  emit;       // load the output register
        t_kind kind;
        logic  last;       // final result of the current input request
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic can_emit;    // output register free or draining
        logic in_zero;     // incoming byte is zero
        logic in_last;     // incoming byte closes the block
        logic run_pend;    // a zero run is waiting to be flushed
        logic bit_last;    // current run bit is the final one
        logic byte_zero;   // held byte is zero
        logic byte_esc;    // held byte needs the escape pair
        logic item_last;   // held byte closed the block
    } t_status;

    localparam logic [7:0] ESC_FIRST = 8'hFE;
    localparam logic [7:0] ESC_CODE  = 8'hFF;
    localparam logic [7:0] FOOT_OK   = 8'h01;
    localparam logic [7:0] FOOT_EXP  = 8'h00;

endpackage

### design/zrle_ctrl.sv
// Controller state machine for the zero run length encoder.
// Sequences run bits, literals, escape tails and the footer.
// Depends on zrle_pkg.
module zrle_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  zrle_pkg::t_status i_status,
    output zrle_pkg::t_cmd    o_cmd
);
    import zrle_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.kind  = K_RUN_BIT;
        o_s_tready  = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.in_zero) begin
                        // a zero closing the block flushes its own run
                        if (i_status.in_last) begin
                            o_cmd.run_start = 1'b1;
                            n_state         = S_RUN;
                        end
                    end else if (i_status.run_pend) begin
                        o_cmd.run_start = 1'b1;
                        n_state         = S_RUN;
                    end else begin
                        n_state = S_LIT;
                    end
                end
            end
            S_RUN: begin
                if (i_status.can_emit) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_RUN_BIT;
                    if (i_status.bit_last) begin
                        n_state = i_status.byte_zero ? S_FOOT : S_LIT;
                    end
                end
            end
            S_LIT: begin
                if (i_status.can_emit) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_LITERAL;
                    o_cmd.last = !i_status.byte_esc && !i_status.item_last;
                    if (i_status.byte_esc) begin
                        n_state = S_ESC;
                    end else if (i_status.item_last) begin
                        n_state = S_FOOT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ESC: begin
                if (i_status.can_emit) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_ESC_TAIL;
                    o_cmd.last = !i_status.item_last;
                    n_state    = i_status.item_last ? S_FOOT : S_IDLE;
                end
            end
            S_FOOT: begin
                if (i_status.can_emit) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_FOOTER;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### design/zrle_dp.sv
// Datapath for the zero run length encoder: block counters, zero run
// length with its leading-one index, held byte and the output register.
// Depends on zrle_pkg.
module zrle_dp #(
    parameter int BLOCK_BITS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_s_tdata,
    input  logic              i_s_tlast,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata,
    output logic [1:0]        o_m_tuser,
    output logic              o_m_tlast,
    input  zrle_pkg::t_cmd    i_cmd,
    output zrle_pkg::t_status o_status
);
    import zrle_pkg::*;

    localparam int W_IN  = BLOCK_BITS + 1;
    localparam int W_OUT = BLOCK_BITS + 2;
    localparam int W_IDX = $clog2(BLOCK_BITS + 1);

    // Control state
    logic [W_IN-1:0]  r_bytes_in,  n_bytes_in;
    logic [W_IN-1:0]  r_run_len,   n_run_len;   // zero run plus one
    logic [W_IDX-1:0] r_run_msb,   n_run_msb;   // leading one of r_run_len
    logic [W_OUT-1:0] r_bytes_out, n_bytes_out;
    logic [W_OUT-1:0] r_tok_mark,  n_tok_mark;
    logic             r_out_valid;

    // Payload
    logic [7:0]       r_byte;
    logic             r_last;
    logic [W_IDX-1:0] r_bit_idx, n_bit_idx;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_out_footer;
    logic             r_out_exp;
    logic             r_out_last;

    logic [W_IN-1:0]  len_inc;
    logic             len_sat;
    logic             len_pow2;
    logic             expanded;
    logic             run_done;
    logic             is_footer;

    // Run length bookkeeping: the leading one moves up when len+1 is a power of two
    assign len_inc   = r_run_len + 1'b1;
    assign len_sat   = r_run_len[BLOCK_BITS] & r_run_len[0];
    assign len_pow2  = ((r_run_len & len_inc) == '0);
    assign run_done  = i_cmd.emit && (i_cmd.kind == K_RUN_BIT) && (r_bit_idx == '0);
    assign is_footer = i_cmd.emit && (i_cmd.kind == K_FOOTER);
    assign expanded  = (r_tok_mark >= {1'b0, r_bytes_in});

    always_comb begin
        n_run_len = r_run_len;
        n_run_msb = r_run_msb;
        if (i_cmd.accept && (i_s_tdata == 8'd0) && !len_sat) begin
            n_run_len = len_inc;
            if (len_pow2) begin
                n_run_msb = r_run_msb + 1'b1;
            end
        end else if (run_done || is_footer) begin
            n_run_len = W_IN'(1);
            n_run_msb = '0;
        end
    end

    // Block byte counters and token mark
    always_comb begin
        n_bytes_in  = r_bytes_in;
        n_bytes_out = r_bytes_out;
        n_tok_mark  = r_tok_mark;
        if (is_footer) begin
            n_bytes_in  = '0;
            n_bytes_out = '0;
            n_tok_mark  = '0;
        end else begin
            if (i_cmd.accept && !r_bytes_in[BLOCK_BITS]) begin
                n_bytes_in = r_bytes_in + 1'b1;
            end
            if (i_cmd.emit && !(&r_bytes_out)) begin
                n_bytes_out = r_bytes_out + 1'b1;
            end
            if (i_cmd.run_start || (i_cmd.emit && (i_cmd.kind == K_LITERAL))) begin
                n_tok_mark = r_bytes_out;
            end
        end
    end

    // Run bit index
    always_comb begin
        n_bit_idx = r_bit_idx;
        if (i_cmd.run_start) begin
            n_bit_idx = n_run_msb - 1'b1;
        end else if (i_cmd.emit && (i_cmd.kind == K_RUN_BIT)) begin
            n_bit_idx = r_bit_idx - 1'b1;
        end
    end

    // Result byte select
    always_comb begin
        case (i_cmd.kind)
            K_RUN_BIT:  n_out_byte = {7'd0, r_run_len[r_bit_idx]};
            K_LITERAL:  n_out_byte = (r_byte >= ESC_FIRST) ? ESC_CODE : r_byte + 8'd1;
            K_ESC_TAIL: n_out_byte = {7'd0, r_byte[0]};
            K_FOOTER:   n_out_byte = expanded ? FOOT_EXP : FOOT_OK;
            default:    n_out_byte = FOOT_OK;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_in  <= '0;
            r_run_len   <= W_IN'(1);
            r_run_msb   <= '0;
            r_bytes_out <= '0;
            r_tok_mark  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_bytes_in  <= n_bytes_in;
            r_run_len   <= n_run_len;
            r_run_msb   <= n_run_msb;
            r_bytes_out <= n_bytes_out;
            r_tok_mark  <= n_tok_mark;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_bit_idx <= n_bit_idx;
        if (i_cmd.accept) begin
            r_byte <= i_s_tdata;
            r_last <= i_s_tlast;
        end
        if (i_cmd.emit) begin
            r_out_byte   <= n_out_byte;
            r_out_footer <= (i_cmd.kind == K_FOOTER);
            r_out_exp    <= (i_cmd.kind == K_FOOTER) && expanded;
            r_out_last   <= i_cmd.last;
        end
    end

    // Status back to the controller
    always_comb begin
        o_status.can_emit  = !r_out_valid || i_m_tready;
        o_status.in_zero   = (i_s_tdata == 8'd0);
        o_status.in_last   = i_s_tlast;
        o_status.run_pend  = (r_run_msb != '0);
        o_status.bit_last  = (r_bit_idx == '0);
        o_status.byte_zero = (r_byte == 8'd0);
        o_status.byte_esc  = (r_byte >= ESC_FIRST);
        o_status.item_last = r_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tuser  = {r_out_exp, r_out_footer};
    assign o_m_tlast  = r_out_last;

endmodule

### design/zero_run_length_encoder.sv
// Zero run length encoder, top level.
// Joins the controller (zrle_ctrl) and the datapath (zrle_dp); uses zrle_pkg.
//
// Takes one byte per request and gives its coded results one per cycle
// through a registered output while the output is not stalled. A new byte
// is taken only when the controller is idle, so each input byte's emit
// sequence is finished before the next byte is taken: a zero byte inside a
// block gives no result, a byte from 0x01 to 0xFD gives one literal, 0xFE
// or 0xFF gives the escape pair; a nonzero byte that ends a run of n zeros
// first gives floor(log2(n+1)) run bits, and the last byte of a block adds
// the footer (after the run bits of a trailing run). Stalls on the output
// hold the sequence. The leading one of the run length is tracked as zeros
// arrive, so no search is needed. Blocks should hold at most 2^BLOCK_BITS
// bytes; beyond that the counters saturate.
module zero_run_length_encoder #(
    parameter int BLOCK_BITS = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,   // in_last
    // output stream
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic [1:0] o_m_tuser,   // [0] is_footer, [1] expanded
    output logic       o_m_tlast    // out_last
);
    import zrle_pkg::*;

    t_cmd    cmd;
    t_status status;

    zrle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    zrle_dp #(
        .BLOCK_BITS (BLOCK_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_cmd      (cmd),
        .o_status   (status)
    );

endmodule

### design/zrle_check.sv
// Port-level checker for the zero run length encoder, with its bind.
// Watches the output stream only; uses zrle_pkg for the footer values.
module zrle_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic [1:0] o_m_tuser,
    input logic       o_m_tlast
);
    import zrle_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // the footer closes the results of its request
    a_foot_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tlast)
        else $error("footer without tlast");

    // expanded is only ever flagged on a footer
    a_exp_foot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> o_m_tuser[0])
        else $error("expanded outside footer");

    // footer value agrees with the expanded flag
    a_foot_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |->
            ((o_m_tuser[1] && (o_m_tdata == FOOT_EXP))
             || (!o_m_tuser[1] && (o_m_tdata == FOOT_OK))))
        else $error("footer value does not match expanded");

endmodule

bind zero_run_length_encoder zrle_check u_zrle_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

### bench/zero_run_length_encoder_tb.sv
// Self-checking bench for zero_run_length_encoder: directed blocks, then random blocks.
// Scores every coded byte against an in-bench model of the coder, under random idling on
// both stream sides. Depends on zrle_pkg and the encoder RTL only.
module zero_run_length_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import zrle_pkg::*;

    localparam int BLOCK_BITS   = 24;
    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 330;
    localparam int CALM_ITEMS   = 30;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [BLOCK_BITS:0]   IN_CAP  = {1'b1, {BLOCK_BITS{1'b0}}};
    localparam logic [BLOCK_BITS+1:0] OUT_CAP = '1;

    // One input request: block byte plus end-of-block flag
    typedef struct packed {
        logic [7:0] val;
        logic       last;
    } t_in_req;

    // One coded result as the encoder should present it
    typedef struct packed {
        logic [7:0] val;
        logic       footer;
        logic       expanded;
        logic       last;
    } t_coded;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic [7:0] i_s_tdata  = '0;    // [7:0] in_byte
    logic       i_s_tlast  = 1'b0;  // in_last
    logic       i_m_tready = 1'b0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;          // [7:0] out_byte
    logic [1:0] o_m_tuser;          // [0] is_footer, [1] expanded
    logic       o_m_tlast;          // out_last

    // Bench model state
    logic [BLOCK_BITS:0]   zero_run;
    logic [BLOCK_BITS:0]   bytes_seen;
    logic [BLOCK_BITS+1:0] out_total;
    logic [BLOCK_BITS+1:0] tok_start;

    t_in_req pending_q[$];
    t_coded  coded_q[$];
    t_in_req next_req;
    t_coded  want;

    int   n_total     = 0;
    int   n_sent      = 0;
    int   n_taken     = 0;
    int   n_results   = 0;
    int   n_blocks    = 0;
    int   n_expanded  = 0;
    int   n_errors    = 0;
    int   n_cycles    = 0;
    int   gap_left    = 0;
    int   stall_left  = 0;
    int   src_idle_pct = 20;
    int   snk_idle_pct = 20;
    logic calm;

    assign calm = (n_sent + CALM_ITEMS >= n_total);

    zero_run_length_encoder #(
        .BLOCK_BITS(BLOCK_BITS)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tlast (i_s_tlast),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .o_m_tlast (o_m_tlast)
    );

    // Clock, 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Queue a coded data byte and bump the saturating output count
    function automatic void emit_data(input logic [7:0] val);
        t_coded c;
        c.val      = val;
        c.footer   = 1'b0;
        c.expanded = 1'b0;
        c.last     = 1'b0;
        coded_q.push_back(c);
        if (out_total < OUT_CAP)
            out_total++;
    endfunction

    // Pending zero run goes out as the bits of run+1 below its leading one
    function automatic void flush_zero_run();
        logic [BLOCK_BITS+1:0] len;
        int msb;
        if (zero_run == '0)
            return;
        tok_start = out_total;
        len = {1'b0, zero_run} + 1'b1;
        msb = 0;
        for (int i = 0; i <= BLOCK_BITS + 1; i++)
            if (len[i])
                msb = i;
        for (int i = msb - 1; i >= 0; i--)
            emit_data({7'd0, len[i]});
        zero_run = '0;
    endfunction

    // Work out every coded result caused by one accepted block byte
    function automatic void encode_byte(input logic [7:0] val, input logic last);
        int   first_idx;
        logic expd;
        t_coded foot;
        first_idx = coded_q.size();
        if (bytes_seen < IN_CAP)
            bytes_seen++;
        if (val == 8'h00) begin
            if (zero_run < IN_CAP)
                zero_run++;
        end else begin
            flush_zero_run();
            tok_start = out_total;
            if (val >= ESC_FIRST) begin
                emit_data(ESC_CODE);
                emit_data((val == ESC_CODE) ? 8'h01 : 8'h00);
            end else begin
                emit_data(val + 8'h01);
            end
        end
        // end of block: trailing run, then the footer, then a fresh block
        if (last) begin
            flush_zero_run();
            expd          = (tok_start >= {1'b0, bytes_seen});
            foot.val      = expd ? FOOT_EXP : FOOT_OK;
            foot.footer   = 1'b1;
            foot.expanded = expd;
            foot.last     = 1'b0;
            coded_q.push_back(foot);
            zero_run   = '0;
            bytes_seen = '0;
            out_total  = '0;
            tok_start  = '0;
        end
        if (coded_q.size() > first_idx)
            coded_q[coded_q.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    function automatic void add_req(input logic [7:0] val, input logic last);
        t_in_req r;
        r.val  = val;
        r.last = last;
        pending_q.push_back(r);
    endfunction

    // Source side: present queued requests, with random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (gap_left > 0 && !calm) begin
                gap_left   <= gap_left - 1;
                i_s_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                next_req = pending_q.pop_front();
                i_s_tdata  <= next_req.val;
                i_s_tlast  <= next_req.last;
                i_s_tvalid <= 1'b1;
                n_sent++;
                if (!calm && $urandom_range(0, 99) < src_idle_pct)
                    gap_left <= $urandom_range(1, 17);
                // new idling mood per block, sometimes none at all
                if (next_req.last)
                    case ($urandom_range(0, 3))
                        0: src_idle_pct = 0;
                        1: src_idle_pct = 10;
                        2: src_idle_pct = 30;
                        default: src_idle_pct = 60;
                    endcase
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: random stall bursts
    always @(posedge i_clk) begin
        if (n_cycles % 100 == 0)
            snk_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (calm) begin
            stall_left <= 0;
            i_m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < snk_idle_pct) begin
            stall_left <= $urandom_range(0, 16);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Predict on each accepted request, then score each accepted result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            zero_run   = '0;
            bytes_seen = '0;
            out_total  = '0;
            tok_start  = '0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                encode_byte(i_s_tdata, i_s_tlast);
                n_taken++;
            end
            if (o_m_tvalid && i_m_tready) begin
                n_results++;
                if (coded_q.size() == 0) begin
                    $error("unexpected result: out_byte 0x%0h, tuser 0x%0h, out_last %0b",
                           o_m_tdata, o_m_tuser, o_m_tlast);
                    n_errors++;
                end else begin
                    want = coded_q.pop_front();
                    check_field("out_byte", want.val, o_m_tdata);
                    check_field("is_footer", want.footer, o_m_tuser[0]);
                    check_field("expanded", want.expanded, o_m_tuser[1]);
                    check_field("out_last", want.last, o_m_tlast);
                    if (want.footer) begin
                        n_blocks++;
                        if (want.expanded)
                            n_expanded++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= LIMIT_CYCLES) begin
            $error("timeout after %0d cycles: %0d of %0d requests taken, %0d results owed",
                   n_cycles, n_taken, n_total, coded_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        logic [8:0] directed [22];
        int n_rand;
        int blen;
        int zero_pct;
        logic [7:0] v;

        // {last, byte}: lone zero, lone literal, escape pair that expands,
        // runs with a trailing zero run, a run of seven, alternating bit patterns
        directed = '{
            9'h100,
            9'h101,
            9'h0FF, 9'h1FE,
            9'h000, 9'h000, 9'h000, 9'h07F, 9'h0FD, 9'h000, 9'h100,
            9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h1FF,
            9'h055, 9'h0AA, 9'h100
        };

        foreach (directed[i])
            add_req(directed[i][7:0], directed[i][8]);

        // Random whole blocks: mostly short, a few long, some zero heavy
        n_rand = 0;
        while (n_rand < RANDOM_ITEMS) begin
            blen     = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                   : $urandom_range(1, 16);
            zero_pct = ($urandom_range(0, 3) == 0) ? 90 : $urandom_range(10, 60);
            for (int k = 0; k < blen; k++) begin
                if ($urandom_range(0, 99) < zero_pct) begin
                    v = 8'h00;
                end else begin
                    case ($urandom_range(0, 9))
                        0:       v = ESC_FIRST;
                        1:       v = ESC_CODE;
                        2:       v = 8'hFD;
                        3:       v = 8'h01;
                        default: v = 8'($urandom_range(1, 255));
                    endcase
                end
                add_req(v, k == blen - 1);
            end
            n_rand += blen;
        end
        n_total = pending_q.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_taken < n_total || coded_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d input bytes in %0d blocks (%0d needing raw copy).",
                 n_taken, n_blocks, n_expanded);
        $display("%0d coded bytes scored over %0d cycles, %0d errors.",
                 n_results, n_cycles, n_errors);
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
